// File: hw/rtl/sgm_pkg.sv
// Shared types, constants and tables for the Sobel gradient block.
`default_nettype none
package sgm_pkg;

  localparam int MAX_WIDTH   = 2048;
  localparam int COL_W       = $clog2(MAX_WIDTH);
  localparam int ROW_W       = 16;
  localparam int WIDTH_W     = 12;
  localparam int PIX_W       = 8;
  localparam int MAG_W       = 11;
  localparam int ANG_W       = 16;
  localparam int CORDIC_STEPS = 28;
  localparam int ITER_W      = 5;
  localparam int SQRT_STEPS  = 11;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 16;

  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 2'd1;

  localparam logic [WIDTH_W-1:0] RESET_WIDTH  = 12'd640;
  localparam logic [ROW_W-1:0]   RESET_HEIGHT = 16'd480;

  // radians Q28 to binary angle: multiply by K, round at bit 48
  localparam logic [63:0] ANG_SCALE = 64'd10937044409;
  localparam logic [16:0] ANG_SCALE_HI = 17'(ANG_SCALE >> 17);
  localparam logic [16:0] ANG_SCALE_LO = 17'(ANG_SCALE & 64'h1FFFF);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOAD,
    ST_PREP,
    ST_ITER,
    ST_MUL_LO,
    ST_MUL_HI,
    ST_FINISH
  } state_t;

  typedef struct packed {
    logic accept;
    logic load;
    logic prep;
    logic iter;
    logic mul_lo;
    logic mul_hi;
    logic finish;
  } cmd_t;

  typedef struct packed {
    logic has_result;
    logic iter_last;
    logic out_full;
  } status_t;

  // atan(2^-i) in radians, Q28
  function automatic logic [28:0] atan_step(input logic [ITER_W-1:0] i);
    logic [28:0] t;
    case (i)
      5'd0:    t = 29'd210828715;
      5'd1:    t = 29'd124459457;
      5'd2:    t = 29'd65760959;
      5'd3:    t = 29'd33381290;
      5'd4:    t = 29'd16755422;
      5'd5:    t = 29'd8385879;
      5'd6:    t = 29'd4193963;
      5'd7:    t = 29'd2097109;
      5'd8:    t = 29'd1048571;
      5'd9:    t = 29'd524287;
      5'd10:   t = 29'd262144;
      5'd11:   t = 29'd131072;
      default: t = 29'd1 << (5'd28 - i);
    endcase
    return t;
  endfunction

endpackage
`default_nettype wire

// File: hw/rtl/sobel_gradient_magnitude_angle.sv
// Interior pixels pass through load, prepare, a 28-step CORDIC loop that
// also forms the rounded square root, a two-part scaling multiply and
// publish; a new pixel is taken only back in idle, and border pixels
// return to idle straight after load. The result register lets the next
// pixel in while a beat waits. Reset: synchronous; width 640, height 480,
// counters and window cleared, line store left as is.
`default_nettype none
module sobel_gradient_magnitude_angle (
  input  wire                              clk,
  input  wire                              rst,
  input  wire                              in_valid,
  output logic                             in_stall,
  input  wire [sgm_pkg::PIX_W-1:0]         pixel,
  input  wire                              cfg_write,
  input  wire [sgm_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire [sgm_pkg::CFG_DATA_W-1:0]    cfg_data,
  output logic                             out_valid,
  input  wire                              out_stall,
  output logic [sgm_pkg::MAG_W-1:0]        grad_magnitude,
  output logic signed [sgm_pkg::ANG_W-1:0] grad_angle,
  output logic [10:0]                      center_col,
  output logic [sgm_pkg::ROW_W-1:0]        center_row,
  output logic                             frame_last
);
  import sgm_pkg::*;

  cmd_t    cmd;
  status_t status;

  sgm_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .status   (status),
    .cmd      (cmd)
  );

  sgm_datapath u_datapath (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .status         (status),
    .pixel          (pixel),
    .cfg_write      (cfg_write),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .grad_magnitude (grad_magnitude),
    .grad_angle     (grad_angle),
    .center_col     (center_col),
    .center_row     (center_row),
    .frame_last     (frame_last)
  );

endmodule
`default_nettype wire

// File: hw/rtl/sgm_ctrl.sv
// Sequencer for one pixel: load, prepare, iterate, scale, publish.
`default_nettype none
module sgm_ctrl (
  input  wire              clk,
  input  wire              rst,
  input  wire              in_valid,
  output logic             in_stall,
  input  sgm_pkg::status_t status,
  output sgm_pkg::cmd_t    cmd
);
  import sgm_pkg::*;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:   if (in_valid) state_next = ST_LOAD;
      ST_LOAD:   state_next = status.has_result ? ST_PREP : ST_IDLE;
      ST_PREP:   state_next = ST_ITER;
      ST_ITER:   if (status.iter_last) state_next = ST_MUL_LO;
      ST_MUL_LO: state_next = ST_MUL_HI;
      ST_MUL_HI: state_next = ST_FINISH;
      ST_FINISH: if (!status.out_full) state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_stall = 1'b1;
    case (state)
      ST_IDLE: begin
        in_stall   = 1'b0;
        cmd.accept = in_valid;
      end
      ST_LOAD:   cmd.load   = 1'b1;
      ST_PREP:   cmd.prep   = 1'b1;
      ST_ITER:   cmd.iter   = 1'b1;
      ST_MUL_LO: cmd.mul_lo = 1'b1;
      ST_MUL_HI: cmd.mul_hi = 1'b1;
      ST_FINISH: cmd.finish = !status.out_full;
      default:   in_stall   = 1'b1;
    endcase
  end

  a_no_result_returns: assert property (@(posedge clk) disable iff (rst)
    (state == ST_LOAD && !status.has_result) |=> state == ST_IDLE)
    else $error("border pixel did not return to idle");

  a_iter_to_scale: assert property (@(posedge clk) disable iff (rst)
    (state == ST_ITER && status.iter_last) |=> state == ST_MUL_LO)
    else $error("iteration did not end in scaling");

  a_finish_publishes: assert property (@(posedge clk) disable iff (rst)
    cmd.finish |=> (state == ST_IDLE && !in_stall))
    else $error("publish did not free the block");

endmodule
`default_nettype wire

// File: hw/rtl/sgm_datapath.sv
// Line store, window, Sobel sums, square root and CORDIC angle unit.
`default_nettype none
module sgm_datapath (
  input  wire                            clk,
  input  wire                            rst,
  input  sgm_pkg::cmd_t                  cmd,
  output sgm_pkg::status_t               status,
  input  wire [sgm_pkg::PIX_W-1:0]       pixel,
  input  wire                            cfg_write,
  input  wire [sgm_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire [sgm_pkg::CFG_DATA_W-1:0]  cfg_data,
  output logic                           out_valid,
  input  wire                            out_stall,
  output logic [sgm_pkg::MAG_W-1:0]      grad_magnitude,
  output logic signed [sgm_pkg::ANG_W-1:0] grad_angle,
  output logic [10:0]                    center_col,
  output logic [sgm_pkg::ROW_W-1:0]      center_row,
  output logic                           frame_last
);
  import sgm_pkg::*;

  logic [WIDTH_W-1:0] image_width;
  logic [ROW_W-1:0]   image_height;
  logic [COL_W-1:0]   col_count;
  logic [ROW_W-1:0]   row_count;

  logic [15:0] row_store [MAX_WIDTH];
  logic [15:0] rd_data;
  logic [PIX_W-1:0] pix;
  logic [COL_W-1:0] cur_c;
  logic [ROW_W-1:0] cur_r;
  logic [23:0] win0, win1;

  logic signed [10:0] dx, dy;
  logic [9:0]  ax, ay;
  logic        swap;
  logic [20:0] sum_sq;
  logic [MAG_W-1:0] root;
  logic signed [33:0] cx, cy;
  logic signed [30:0] acc;
  logic [ITER_W-1:0] iter;
  logic [45:0] prod_lo, prod_hi;

  logic [10:0] res_col;
  logic [ROW_W-1:0] res_row;
  logic res_last;

  // effective frame size
  logic [WIDTH_W-1:0] w_eff;
  logic [ROW_W-1:0]   h_eff;
  logic [COL_W-1:0]   c_eff;
  logic [ROW_W-1:0]   r_eff;

  always_comb begin
    if (image_width < 12'd3) w_eff = 12'd3;
    else if (image_width > WIDTH_W'(MAX_WIDTH)) w_eff = WIDTH_W'(MAX_WIDTH);
    else w_eff = image_width;
    h_eff = (image_height < 16'd3) ? 16'd3 : image_height;
    c_eff = ({1'b0, col_count} >= w_eff) ? '0 : col_count;
    r_eff = (row_count >= h_eff) ? '0 : row_count;
  end

  // configuration and position counters
  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= RESET_WIDTH;
      image_height <= RESET_HEIGHT;
      col_count    <= '0;
      row_count    <= '0;
    end else if (cfg_write) begin
      if (cfg_index == REG_IMAGE_WIDTH) begin
        image_width <= cfg_data[WIDTH_W-1:0];
        col_count   <= '0;
        row_count   <= '0;
      end else if (cfg_index == REG_IMAGE_HEIGHT) begin
        image_height <= cfg_data;
        col_count    <= '0;
        row_count    <= '0;
      end
    end else if (cmd.load) begin
      if ({1'b0, cur_c} + 12'd1 >= w_eff) begin
        col_count <= '0;
        row_count <= ({1'b0, cur_r} + 17'd1 >= {1'b0, h_eff}) ? '0 : cur_r + 16'd1;
      end else begin
        col_count <= cur_c + 1'b1;
        row_count <= cur_r;
      end
    end
  end

  // line store: read on accept, write back shifted column on load
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      rd_data <= row_store[c_eff];
    end
    if (cmd.load) begin
      row_store[cur_c] <= {rd_data[7:0], pix};
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      pix   <= pixel;
      cur_c <= c_eff;
      cur_r <= r_eff;
    end
  end

  // Sobel sums over the window
  logic [23:0] col_now;
  logic [9:0]  sx_r, sx_l, sy_b, sy_t;
  logic signed [11:0] dx_w, dy_w;

  always_comb begin
    col_now = {rd_data, pix};
    sx_r = 10'(col_now[23:16]) + {1'b0, col_now[15:8], 1'b0} + 10'(col_now[7:0]);
    sx_l = 10'(win0[23:16]) + {1'b0, win0[15:8], 1'b0} + 10'(win0[7:0]);
    sy_b = 10'(win0[7:0]) + {1'b0, win1[7:0], 1'b0} + 10'(col_now[7:0]);
    sy_t = 10'(win0[23:16]) + {1'b0, win1[23:16], 1'b0} + 10'(col_now[23:16]);
    dx_w = $signed({2'b0, sx_r}) - $signed({2'b0, sx_l});
    dy_w = $signed({2'b0, sy_b}) - $signed({2'b0, sy_t});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      win0 <= '0;
      win1 <= '0;
    end else if (cmd.load) begin
      win0 <= win1;
      win1 <= col_now;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      dx       <= dx_w[10:0];
      dy       <= dy_w[10:0];
      res_col  <= 11'(cur_c - 1'b1);
      res_row  <= cur_r - 16'd1;
      res_last <= (cur_r == h_eff - 16'd1) && ({1'b0, cur_c} == w_eff - 12'd1);
    end
  end

  // shared square-root multiplier: trial bit, then rounding check
  logic [MAG_W-1:0] trial, sq_op;
  logic [21:0]      sq;

  always_comb begin
    trial = root | (MAG_W'(1) << (4'd10 - iter[3:0]));
    sq_op = (iter < ITER_W'(SQRT_STEPS)) ? trial : root;
    sq    = sq_op * sq_op;
  end

  // CORDIC step
  logic signed [33:0] xs, ys;
  logic [28:0] acc_pos;

  always_comb begin
    xs = cx >>> iter;
    ys = cy >>> iter;
    acc_pos = acc[30] ? '0 : acc[28:0];
  end

  logic [9:0] big, small_v, ax_w, ay_w;
  always_comb begin
    ax_w = dx[10] ? 10'(-dx) : dx[9:0];
    ay_w = dy[10] ? 10'(-dy) : dy[9:0];
    big     = (ay_w < ax_w) ? ax_w : ay_w;
    small_v = (ay_w < ax_w) ? ay_w : ax_w;
  end

  always_ff @(posedge clk) begin
    if (cmd.prep) begin
      ax     <= ax_w;
      ay     <= ay_w;
      swap   <= !(ay_w < ax_w);
      sum_sq <= 21'(ax_w * ax_w) + 21'(ay_w * ay_w);
      root   <= '0;
      cx     <= 34'(big) << 20;
      cy     <= 34'(small_v) << 20;
      acc    <= '0;
      iter   <= '0;
    end else if (cmd.iter) begin
      if (cy > 0) begin
        cx  <= cx + ys;
        cy  <= cy - xs;
        acc <= acc + 31'(atan_step(iter));
      end else begin
        cx  <= cx - ys;
        cy  <= cy + xs;
        acc <= acc - 31'(atan_step(iter));
      end
      if (iter < ITER_W'(SQRT_STEPS)) begin
        if (sq <= 22'(sum_sq)) root <= trial;
      end else if (iter == ITER_W'(SQRT_STEPS)) begin
        if (22'(sum_sq) - sq > 22'(root)) root <= root + 1'b1;
      end
      iter <= iter + 1'b1;
    end else if (cmd.mul_lo) begin
      prod_lo <= 46'(acc_pos * ANG_SCALE_LO);
    end else if (cmd.mul_hi) begin
      prod_hi <= 46'(acc_pos * ANG_SCALE_HI);
    end
  end

  // scale to binary angle, fold into the right quadrant
  logic [63:0] scaled;
  logic [15:0] u;
  logic [13:0] oct;
  logic [14:0] q;
  logic signed [16:0] ang;

  always_comb begin
    scaled = ({18'b0, prod_hi} << 17) + {18'b0, prod_lo} + (64'd1 << 47);
    u   = scaled[63:48];
    oct = (u > 16'd8192) ? 14'd8192 : u[13:0];
    if (ay == '0) q = '0;
    else if (ax == ay) q = 15'd8192;
    else if (!swap) q = 15'(oct);
    else q = 15'd16384 - 15'(oct);
    if (!dx[10]) ang = !dy[10] ? $signed({2'b0, q}) : -$signed({2'b0, q});
    else ang = !dy[10] ? 17'sd32768 - $signed({2'b0, q})
                       : $signed({2'b0, q}) - 17'sd32768;
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.finish) begin
      out_valid <= 1'b1;
    end else if (out_valid && !out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      grad_magnitude <= root;
      grad_angle     <= ang[15:0];
      center_col     <= res_col;
      center_row     <= res_row;
      frame_last     <= res_last;
    end
  end

  always_comb begin
    status.has_result = (cur_r >= 16'd2) && (cur_c >= COL_W'(2));
    status.iter_last  = (iter == ITER_W'(CORDIC_STEPS - 1));
    status.out_full   = out_valid && out_stall;
  end

endmodule
`default_nettype wire

// File: tb/sobel_gradient_magnitude_angle_test.sv
// Self-checking testbench for the streaming Sobel magnitude and angle block.
`timescale 1ns / 100ps
`default_nettype none
module sobel_gradient_magnitude_angle_test;
  import sgm_pkg::*;

  localparam int CYCLE_LIMIT = 3000000;
  localparam int DRAIN_WAIT  = 40;

  typedef struct {
    logic [MAG_W-1:0]        mag;
    logic signed [ANG_W-1:0] ang;
    logic [10:0]             col;
    logic [ROW_W-1:0]        row;
    logic                    last;
  } grad_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [PIX_W-1:0] pixel = '0;
  logic cfg_write = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = REG_IMAGE_WIDTH;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [MAG_W-1:0] grad_magnitude;
  logic signed [ANG_W-1:0] grad_angle;
  logic [10:0] center_col;
  logic [ROW_W-1:0] center_row;
  logic frame_last;

  logic [PIX_W-1:0] pixel_q[$];
  grad_t grad_q[$];
  int errors = 0;
  int cyc = 0;
  bit long_hold_done = 0;
  int hold_left = 0;

  // predictor state
  logic [15:0] line_mem[MAX_WIDTH];
  logic [23:0] win_l, win_m;
  int unsigned p_col, p_row;
  logic [WIDTH_W-1:0] p_width;
  logic [ROW_W-1:0] p_height;

  sobel_gradient_magnitude_angle uut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .pixel(pixel),
    .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .out_valid(out_valid), .out_stall(out_stall),
    .grad_magnitude(grad_magnitude), .grad_angle(grad_angle),
    .center_col(center_col), .center_row(center_row), .frame_last(frame_last)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic int unsigned rounded_root(int unsigned s);
    int unsigned r;
    r = 0;
    for (int b = 11; b >= 0; b--) begin
      if ((r + (1 << b)) * (r + (1 << b)) <= s) r = r + (1 << b);
    end
    if (s - r * r > r) r++;
    return r;
  endfunction

  function automatic longint octant_units(longint big, longint sml);
    longint x, y, acc, t, xs, ys;
    longint unsigned u;
    x = big << 20;
    y = sml << 20;
    acc = 0;
    for (int i = 0; i < CORDIC_STEPS; i++) begin
      case (i)
        0: t = 210828715;  1: t = 124459457;  2: t = 65760959;  3: t = 33381290;
        4: t = 16755422;   5: t = 8385879;    6: t = 4193963;   7: t = 2097109;
        8: t = 1048571;    9: t = 524287;     10: t = 262144;   11: t = 131072;
        default: t = longint'(1) << (28 - i);
      endcase
      xs = x >>> i;
      ys = y >>> i;
      if (y > 0) begin
        x = x + ys; y = y - xs; acc = acc + t;
      end else begin
        x = x - ys; y = y + xs; acc = acc - t;
      end
    end
    if (acc < 0) acc = 0;
    u = (longint'(acc) * 64'd10937044409 + (64'd1 << 47)) >> 48;
    if (u > 8192) u = 8192;
    return longint'(u);
  endfunction

  function automatic logic [15:0] direction_units(int dx, int dy);
    int ax, ay, q, a;
    ax = dx < 0 ? -dx : dx;
    ay = dy < 0 ? -dy : dy;
    if (ay == 0) q = 0;
    else if (ax == ay) q = 8192;
    else if (ay < ax) q = int'(octant_units(ax, ay));
    else q = 16384 - int'(octant_units(ay, ax));
    if (dx >= 0) a = (dy >= 0) ? q : -q;
    else a = (dy >= 0) ? 32768 - q : q - 32768;
    return a[15:0];
  endfunction

  // predictor: follow config writes and accepted pixel beats
  always @(posedge clk) begin
    int unsigned w, h, c, r, top, mid;
    int lt, lm, lb, mt, mb, rt, rm, rb, dx, dy;
    logic [23:0] colv;
    grad_t g;
    if (rst) begin
      win_l = '0; win_m = '0; p_col = 0; p_row = 0;
      p_width = RESET_WIDTH; p_height = RESET_HEIGHT;
    end else if (cfg_write && (cfg_index == REG_IMAGE_WIDTH || cfg_index == REG_IMAGE_HEIGHT)) begin
      if (cfg_index == REG_IMAGE_WIDTH) p_width = cfg_data[WIDTH_W-1:0];
      else p_height = cfg_data;
      p_col = 0; p_row = 0;
    end else if (in_valid && !in_stall) begin
      w = p_width; h = p_height; c = p_col; r = p_row;
      if (w < 3) w = 3;
      if (w > MAX_WIDTH) w = MAX_WIDTH;
      if (h < 3) h = 3;
      if (c >= w) c = 0;
      if (r >= h) r = 0;
      top = line_mem[c][15:8];
      mid = line_mem[c][7:0];
      line_mem[c] = {mid[7:0], pixel};
      colv = {top[7:0], mid[7:0], pixel};
      if (r >= 2 && c >= 2) begin
        lt = win_l[23:16]; lm = win_l[15:8]; lb = win_l[7:0];
        mt = win_m[23:16]; mb = win_m[7:0];
        rt = colv[23:16]; rm = colv[15:8]; rb = colv[7:0];
        dx = (rt + 2 * rm + rb) - (lt + 2 * lm + lb);
        dy = (lb + 2 * mb + rb) - (lt + 2 * mt + rt);
        g.mag = MAG_W'(rounded_root(dx * dx + dy * dy));
        g.ang = direction_units(dx, dy);
        g.col = 11'(c - 1);
        g.row = 16'(r - 1);
        g.last = (r == h - 1 && c == w - 1);
        grad_q.push_back(g);
      end
      win_l = win_m;
      win_m = colv;
      c++;
      if (c >= w) begin
        c = 0;
        r++;
        if (r >= h) r = 0;
      end
      p_col = c; p_row = r;
    end
  end

  function automatic bit calm();
    return cyc > 30000 && cyc < 42000;
  endfunction

  // pixel driver
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || !in_stall) begin
      if (pixel_q.size() > 0 && (calm() || $urandom_range(0, 99) >= 21)) begin
        pixel <= pixel_q.pop_front();
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // result side stall, with one long hold once a beat waits and pixels remain
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else if (!long_hold_done && out_valid && pixel_q.size() > 8) begin
      long_hold_done <= 1;
      hold_left <= 400;
      out_stall <= 1'b1;
    end else begin
      out_stall <= !calm() && $urandom_range(0, 99) < 21;
    end
  end

  // result checker
  always @(posedge clk) begin
    grad_t g;
    if (!rst && out_valid && !out_stall) begin
      if (grad_q.size() == 0) begin
        $error("unexpected result beat col %0d row %0d", center_col, center_row);
        errors++;
      end else begin
        g = grad_q.pop_front();
        if (grad_magnitude !== g.mag) begin
          $error("grad_magnitude expected %0d actual %0d", g.mag, grad_magnitude);
          errors++;
        end
        if (grad_angle !== g.ang) begin
          $error("grad_angle expected %0d actual %0d", g.ang, grad_angle);
          errors++;
        end
        if (center_col !== g.col) begin
          $error("center_col expected %0d actual %0d", g.col, center_col);
          errors++;
        end
        if (center_row !== g.row) begin
          $error("center_row expected %0d actual %0d", g.row, center_row);
          errors++;
        end
        if (frame_last !== g.last) begin
          $error("frame_last expected %0d actual %0d", g.last, frame_last);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cyc <= cyc + 1;
    if (cyc > CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  task automatic wait_idle();
    do @(negedge clk);
    while (pixel_q.size() > 0 || in_valid || grad_q.size() > 0);
    repeat (DRAIN_WAIT) @(negedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    @(posedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_write <= 1'b0;
  endtask

  task automatic set_frame(int w, int h);
    wait_idle();
    write_reg(REG_IMAGE_WIDTH, {4'($urandom), 12'(w)});
    write_reg(REG_IMAGE_HEIGHT, 16'(h));
  endtask

  // mode 0 random, 1 extremes only, 2 flat, 3 smooth ramp
  task automatic push_pixels(int n, int mode);
    int base;
    base = $urandom_range(0, 255);
    for (int i = 0; i < n; i++) begin
      case (mode)
        0: pixel_q.push_back(8'($urandom));
        1: pixel_q.push_back($urandom_range(0, 1) ? 8'hFF : 8'h00);
        2: pixel_q.push_back(8'(base));
        default: pixel_q.push_back(8'(base + i * $urandom_range(0, 3)));
      endcase
    end
  endtask

  initial begin
    int w, h, cw, ch, n, fed;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // flat, vertical step (angle of pi), diagonal ramp (equal components)
    set_frame(3, 3);
    repeat (9) pixel_q.push_back(8'd128);
    for (int r = 0; r < 3; r++) begin
      pixel_q.push_back(8'd255); pixel_q.push_back(8'd128); pixel_q.push_back(8'd0);
    end
    for (int r = 0; r < 3; r++)
      for (int c = 0; c < 3; c++) pixel_q.push_back(8'((r + c) * 60));

    // tall frame and out of range sizes clamped
    set_frame(3, 65535);
    push_pixels(60, 0);
    set_frame(0, 2);
    push_pixels(18, 1);

    fed = 0;
    while (fed < 2000) begin
      if ($urandom_range(0, 9) == 0) begin
        w = $urandom_range(0, 40);
        h = $urandom_range(0, 12);
      end else begin
        w = $urandom_range(3, 10);
        h = $urandom_range(3, 8);
      end
      cw = w < 3 ? 3 : w;
      ch = h < 3 ? 3 : h;
      set_frame(w, h);
      n = cw * ch * $urandom_range(1, 3);
      if ($urandom_range(0, 4) == 0) n = $urandom_range(1, n);
      if (n > 2000 - fed) n = 2000 - fed;
      push_pixels(n, $urandom_range(0, 9) < 6 ? 0 : $urandom_range(1, 3));
      fed += n;
    end

    wait_idle();
    repeat (100) @(negedge clk);
    if (errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
`default_nettype wire
